/* src/n2a_pkg.sv */
// ----------------------------------------------------------------------------
// n2a_pkg: shared types and constants for the number to ASCII formatter
// Item layouts, mode codes, character constants and the digit-to-ASCII map.
// ----------------------------------------------------------------------------
package n2a_pkg;

  localparam int BIN_W      = 32;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int BCD_W      = 4 * DEC_DIGITS;

  localparam logic [2:0] MODE_DEC     = 3'd0;
  localparam logic [2:0] MODE_HEX_PFX = 3'd1;
  localparam logic [2:0] MODE_HEX     = 3'd2;
  localparam logic [2:0] MODE_CHAR    = 3'd3;
  localparam logic [2:0] MODE_UNKNOWN = 3'd4;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  typedef struct packed {
    logic [2:0]       mode;
    logic [BIN_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_item_t;

  // Map one digit (decimal or hex) to its uppercase ASCII code.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_UPPER_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* src/n2a_bcd.sv */
// ----------------------------------------------------------------------------
// n2a_bcd: iterative binary to BCD converter
// Shift-add-3 over one bit per cycle from start until done.
// ----------------------------------------------------------------------------
module n2a_bcd (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [n2a_pkg::BIN_W-1:0] bin,
  output logic                     done,
  output logic [n2a_pkg::BCD_W-1:0] bcd
);
  import n2a_pkg::*;

  localparam int CNT_W = $clog2(BIN_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(BIN_W - 1);
      bin_nxt  = bin;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[BIN_W-1]};
      bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

/* src/number_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// number_to_ascii_formatter: integer to decimal / hex / character ASCII text
// Takes one request (mode, value) and emits its characters one per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one request: mode and a 32-bit value.
//   out_valid/out_stall/out_data carry one ASCII character per item, most
//   significant first, with last set on the final character of a request.
//   A request is taken only while the block is idle; in_stall stays high
//   until its final character has been loaded into the output register.
//   Signed decimal runs the shift-add-3 BCD unit on the magnitude: the
//   accept edge loads it, it shifts in every bit and then hands the digits
//   over. Then an optional '-' goes out, leading zero digits are dropped one
//   per cycle, the skip state then turns to output, and the kept digits go
//   out one per cycle while the output is not stalled; dropped plus kept
//   digits are always 10. Hex requests skip the BCD unit, as do a single
//   character and a directive.
//   Modes 5 to 7 are accepted and produce no item.
//   Reset (rst_n low, synchronous) returns to idle and empties the output.
//   When out_stall is high on a valid item, it holds and the output states wait.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  n2a_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output n2a_pkg::out_item_t  out_data
);
  import n2a_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_PRE   = 3'd2;
  localparam logic [2:0] ST_SKIP  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [15:0]      pre_r, pre_nxt;
  logic [1:0]       pre_n_r, pre_n_nxt;
  logic             has_dig_r, has_dig_nxt;
  logic [BCD_W-1:0] dig_r, dig_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             accept;
  logic             can_put;
  logic             bcd_start;
  logic             bcd_done;
  logic [BCD_W-1:0] bcd_val;
  logic [BIN_W-1:0] mag;

  assign accept  = in_valid && (state_r == ST_IDLE);
  assign can_put = !out_valid_r || !out_stall;
  assign mag     = in_data.value[BIN_W-1] ? (BIN_W'(0) - in_data.value) : in_data.value;

  n2a_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .bin   (mag),
    .done  (bcd_done),
    .bcd   (bcd_val)
  );

  always_comb begin
    state_nxt     = state_r;
    pre_nxt       = pre_r;
    pre_n_nxt     = pre_n_r;
    has_dig_nxt   = has_dig_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    bcd_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            MODE_DEC: begin
              has_dig_nxt = 1'b1;
              pre_nxt     = {CH_MINUS, 8'h00};
              pre_n_nxt   = {1'b0, in_data.value[BIN_W-1]};
              bcd_start   = 1'b1;
              state_nxt   = ST_CONV;
            end
            MODE_HEX_PFX: begin
              has_dig_nxt = 1'b1;
              pre_nxt     = {CH_ZERO, CH_X};
              pre_n_nxt   = 2'd2;
              dig_nxt     = {in_data.value, 8'h00};
              cnt_nxt     = 4'(HEX_DIGITS);
              state_nxt   = ST_PRE;
            end
            MODE_HEX: begin
              has_dig_nxt = 1'b1;
              pre_n_nxt   = 2'd0;
              dig_nxt     = {in_data.value, 8'h00};
              cnt_nxt     = 4'(HEX_DIGITS);
              state_nxt   = ST_SKIP;
            end
            MODE_CHAR: begin
              has_dig_nxt = 1'b0;
              pre_nxt     = {in_data.value[7:0], 8'h00};
              pre_n_nxt   = 2'd1;
              state_nxt   = ST_PRE;
            end
            MODE_UNKNOWN: begin
              has_dig_nxt = 1'b0;
              pre_nxt     = {CH_PERCENT, in_data.value[7:0]};
              pre_n_nxt   = 2'd2;
              state_nxt   = ST_PRE;
            end
            default: begin
              // drop undefined modes
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_CONV: begin
        if (bcd_done) begin
          dig_nxt   = bcd_val;
          cnt_nxt   = 4'(DEC_DIGITS);
          state_nxt = (pre_n_r != 2'd0) ? ST_PRE : ST_SKIP;
        end
      end

      ST_PRE: begin
        if (can_put) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = pre_r[15:8];
          out_data_nxt.last      = (pre_n_r == 2'd1) && !has_dig_r;
          pre_nxt                = {pre_r[7:0], 8'h00};
          pre_n_nxt              = pre_n_r - 2'd1;
          if (pre_n_r == 2'd1) begin
            state_nxt = has_dig_r ? ST_SKIP : ST_IDLE;
          end
        end
      end

      ST_SKIP: begin
        // drop leading zero digits, always keep the final one
        if (dig_r[BCD_W-1 -: 4] == 4'd0 && cnt_r > 4'd1) begin
          dig_nxt = {dig_r[BCD_W-5:0], 4'd0};
          cnt_nxt = cnt_r - 4'd1;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end

      ST_DIGIT: begin
        if (can_put) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = digit_char(dig_r[BCD_W-1 -: 4]);
          out_data_nxt.last      = (cnt_r == 4'd1);
          dig_nxt                = {dig_r[BCD_W-5:0], 4'd0};
          cnt_nxt                = cnt_r - 4'd1;
          if (cnt_r == 4'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pre_n_r     <= 2'd0;
      has_dig_r   <= 1'b0;
      cnt_r       <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pre_n_r     <= pre_n_nxt;
      has_dig_r   <= has_dig_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pre_r      <= pre_nxt;
    dig_r      <= dig_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
